/* rtl/pfmt_pkg.sv */
// ----------------------------------------------------------------------------
// pfmt_pkg: shared types and constants of the integer/char formatter
// Holds the request kind codes, the internal operation codes, the command
// record that travels from the front end to the back end, and the tables
// used for digit generation.
// ----------------------------------------------------------------------------
package pfmt_pkg;

    // Request kind codes as seen on the input port.
    localparam logic [2:0] KIND_CHAR    = 3'd0;
    localparam logic [2:0] KIND_HEX_LO  = 3'd1;
    localparam logic [2:0] KIND_HEX_UP  = 3'd2;
    localparam logic [2:0] KIND_DEC     = 3'd3;
    localparam logic [2:0] KIND_PERCENT = 3'd4;

    // Internal operation codes carried by a command.
    localparam logic [1:0] OP_CHAR = 2'd0;
    localparam logic [1:0] OP_HEX  = 2'd1;
    localparam logic [1:0] OP_DEC  = 2'd2;

    // ASCII characters used by the formatter.
    localparam logic [7:0] ASCII_ZERO    = 8'h30;
    localparam logic [7:0] ASCII_MINUS   = 8'h2D;
    localparam logic [7:0] ASCII_PERCENT = 8'h25;
    localparam logic [7:0] ASCII_LOWER_A = 8'h61;
    localparam logic [7:0] ASCII_UPPER_A = 8'h41;

    // Depth of the command queue between front and back end.
    localparam int QDEPTH = 2;
    localparam int QAW    = $clog2(QDEPTH);

    // Powers of ten by digit position; positions past nine are never used.
    localparam logic [31:0] POW10 [16] = '{
        32'd1, 32'd10, 32'd100, 32'd1000, 32'd10000, 32'd100000,
        32'd1000000, 32'd10000000, 32'd100000000, 32'd1000000000,
        32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0
    };

    // One classified conversion request.
    typedef struct packed {
        logic [1:0]  op;     // operation code
        logic        neg;    // decimal value is negative, emit a minus first
        logic        upper;  // upper-case hex digits
        logic [3:0]  top;    // index of the most significant digit
        logic [31:0] val;    // byte, hex value or decimal magnitude
    } t_cmd;

    // Map a nibble to its ASCII hex digit.
    function automatic logic [7:0] hex_char(input logic [3:0] nib, input logic upper);
        logic [7:0] base;
        base = upper ? ASCII_UPPER_A : ASCII_LOWER_A;
        if (nib < 4'd10) begin
            hex_char = ASCII_ZERO + {4'b0, nib};
        end else begin
            hex_char = base + {4'b0, nib} - 8'd10;
        end
    endfunction

endpackage

/* rtl/pfmt_front.sv */
// ----------------------------------------------------------------------------
// pfmt_front: request classifier
// Decodes the request kind, forms the decimal magnitude and finds the
// position of the leading digit, then writes a command into the queue.
// Unknown kinds are accepted and dropped.
// ----------------------------------------------------------------------------
module pfmt_front (
    input  logic            i_push,
    input  logic            i_full,
    input  logic [2:0]      i_kind,
    input  logic [31:0]     i_value,
    output logic            o_wr,
    output pfmt_pkg::t_cmd  o_cmd
);

    logic [31:0] mag;
    logic [3:0]  hex_top;
    logic [3:0]  dec_top;
    logic        known;

    // Magnitude of the two's complement value.
    assign mag = i_value[31] ? (~i_value + 32'd1) : i_value;

    // Leading nonzero nibble; zero still yields one digit.
    always_comb begin
        hex_top = 4'd0;
        for (int i = 0; i < 8; i++) begin
            if (i_value[i*4 +: 4] != 4'd0) begin
                hex_top = 4'(i);
            end
        end
    end

    // Decimal digit count less one: how many powers of ten the magnitude reaches.
    always_comb begin
        dec_top = 4'd0;
        for (int k = 1; k < 10; k++) begin
            dec_top = dec_top + {3'b0, (mag >= pfmt_pkg::POW10[k])};
        end
    end

    // Build the command for the back end.
    always_comb begin
        o_cmd = '0;
        known = 1'b1;
        unique case (i_kind)
            pfmt_pkg::KIND_CHAR: begin
                o_cmd.op  = pfmt_pkg::OP_CHAR;
                o_cmd.val = {24'b0, i_value[7:0]};
            end
            pfmt_pkg::KIND_HEX_LO, pfmt_pkg::KIND_HEX_UP: begin
                o_cmd.op    = pfmt_pkg::OP_HEX;
                o_cmd.upper = (i_kind == pfmt_pkg::KIND_HEX_UP);
                o_cmd.top   = hex_top;
                o_cmd.val   = i_value;
            end
            pfmt_pkg::KIND_DEC: begin
                o_cmd.op  = pfmt_pkg::OP_DEC;
                o_cmd.neg = i_value[31];
                o_cmd.top = dec_top;
                o_cmd.val = mag;
            end
            pfmt_pkg::KIND_PERCENT: begin
                o_cmd.op  = pfmt_pkg::OP_CHAR;
                o_cmd.val = {24'b0, pfmt_pkg::ASCII_PERCENT};
            end
            default: begin
                known = 1'b0;
            end
        endcase
    end

    // Only recognized requests enter the queue.
    assign o_wr = i_push && !i_full && known;

endmodule

/* rtl/pfmt_queue.sv */
// ----------------------------------------------------------------------------
// pfmt_queue: command queue
// A short first-in first-out buffer of commands that lets the classifier
// and the character generator stall independently.
// ----------------------------------------------------------------------------
module pfmt_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_wr,
    input  pfmt_pkg::t_cmd  i_cmd,
    input  logic            i_rd,
    output logic            o_full,
    output logic            o_empty,
    output pfmt_pkg::t_cmd  o_cmd
);

    pfmt_pkg::t_cmd              r_mem [pfmt_pkg::QDEPTH];
    logic [pfmt_pkg::QAW-1:0]    r_wp;
    logic [pfmt_pkg::QAW-1:0]    r_rp;
    logic [pfmt_pkg::QAW:0]      r_cnt;
    logic [pfmt_pkg::QAW:0]      n_cnt;
    logic                        do_wr;
    logic                        do_rd;

    assign o_full  = (r_cnt == (pfmt_pkg::QAW + 1)'(pfmt_pkg::QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_wr   = i_wr && !o_full;
    assign do_rd   = i_rd && !o_empty;
    assign o_cmd   = r_mem[r_rp];

    // Occupancy follows the transfers on both sides.
    always_comb begin
        n_cnt = r_cnt;
        if (do_wr && !do_rd) begin
            n_cnt = r_cnt + (pfmt_pkg::QAW + 1)'(1);
        end else if (do_rd && !do_wr) begin
            n_cnt = r_cnt - (pfmt_pkg::QAW + 1)'(1);
        end
    end

    // Pointers and count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (do_wr) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_rd) begin
                r_rp <= r_rp + 1'b1;
            end
        end
    end

    // Storage.
    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

endmodule

/* rtl/pfmt_back.sv */
// ----------------------------------------------------------------------------
// pfmt_back: character generator
// Takes one command at a time and emits its characters, most significant
// digit first, one per cycle into an output register while that register is
// empty or being popped. Decimal digits come from comparing the remainder
// against the nine multiples of the current power of ten.
module pfmt_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_empty,
    input  pfmt_pkg::t_cmd  i_cmd,
    output logic            o_q_rd,
    input  logic            i_pop,
    output logic            o_empty,
    output logic [7:0]      o_character,
    output logic            o_last,
    output logic [3:0]      o_char_count
);

    // Working registers of the active command.
    logic        r_busy;
    logic [1:0]  r_op;
    logic        r_neg;
    logic        r_upper;
    logic [3:0]  r_pos;
    logic [31:0] r_val;
    logic [3:0]  r_run;

    // Output register.
    logic        r_ovalid;
    logic [7:0]  r_char;
    logic        r_last;
    logic [3:0]  r_cnt;

    logic        adv;
    logic [7:0]  e_char;
    logic        e_last;
    logic [3:0]  dig;
    logic [31:0] sub;
    logic [33:0] mult;
    logic [31:0] p;

    // A character moves forward when the output register is free or drains.
    assign adv    = r_busy && (!r_ovalid || i_pop);
    assign o_q_rd = !r_busy && !i_q_empty;

    // Decimal digit at the current position; a chosen multiple never exceeds
    // the remainder, so it fits in 32 bits.
    always_comb begin
        p    = pfmt_pkg::POW10[r_pos];
        dig  = 4'd0;
        sub  = '0;
        mult = '0;
        for (int m = 1; m < 10; m++) begin
            mult = {2'b0, p} * 34'(m);
            if ({2'b0, r_val} >= mult) begin
                dig = 4'(m);
                sub = mult[31:0];
            end
        end
    end

    // Character selection for the active command.
    always_comb begin
        e_char = r_val[7:0];
        e_last = 1'b1;
        unique case (r_op)
            pfmt_pkg::OP_HEX: begin
                e_char = pfmt_pkg::hex_char(r_val[{r_pos[2:0], 2'b00} +: 4], r_upper);
                e_last = (r_pos == 4'd0);
            end
            pfmt_pkg::OP_DEC: begin
                if (r_neg) begin
                    e_char = pfmt_pkg::ASCII_MINUS;
                    e_last = 1'b0;
                end else begin
                    e_char = pfmt_pkg::ASCII_ZERO + {4'b0, dig};
                    e_last = (r_pos == 4'd0);
                end
            end
            default: begin
                e_char = r_val[7:0];
                e_last = 1'b1;
            end
        endcase
    end

    // Command control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (o_q_rd) begin
            r_busy <= 1'b1;
        end else if (adv && e_last) begin
            r_busy <= 1'b0;
        end
    end

    // Command working state.
    always_ff @(posedge i_clk) begin
        if (o_q_rd) begin
            r_op    <= i_cmd.op;
            r_neg   <= i_cmd.neg;
            r_upper <= i_cmd.upper;
            r_pos   <= i_cmd.top;
            r_val   <= i_cmd.val;
            r_run   <= 4'd0;
        end else if (adv) begin
            r_run <= r_run + 4'd1;
            if (r_op == pfmt_pkg::OP_DEC && r_neg) begin
                r_neg <= 1'b0;
            end else begin
                r_pos <= r_pos - 4'd1;
                if (r_op == pfmt_pkg::OP_DEC) begin
                    r_val <= r_val - sub;
                end
            end
        end
    end

    // Output register valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (adv) begin
            r_ovalid <= 1'b1;
        end else if (i_pop) begin
            r_ovalid <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_char <= e_char;
            r_last <= e_last;
            r_cnt  <= r_run + 4'd1;
        end
    end

    assign o_empty      = !r_ovalid;
    assign o_character  = r_char;
    assign o_last       = r_last;
    assign o_char_count = r_cnt;

endmodule

/* rtl/printf_integer_char_formatter.sv */
// ----------------------------------------------------------------------------
// printf_integer_char_formatter: integer and character conversion unit
// Each request (kind, 32-bit value) yields the ASCII text of one conversion,
// one character per result transfer, most significant digit first, with the
// final character marked and a running character count. Requests are taken
// into a two-entry command queue, which keeps accepting while the character
// generator works on one request at a time: it loads the request and then
// emits its characters, waiting on pop whenever the output register is full.
// Unknown kinds produce no characters.
// ----------------------------------------------------------------------------
module printf_integer_char_formatter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [2:0]  i_kind,
    input  logic [31:0] i_value,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_character,
    output logic        o_last,
    output logic [3:0]  o_char_count
);

    pfmt_pkg::t_cmd f_cmd;
    pfmt_pkg::t_cmd q_cmd;
    logic           f_wr;
    logic           q_full;
    logic           q_empty;
    logic           q_rd;

    assign full = q_full;

    // Request classification.
    pfmt_front u_front (
        .i_push  (push),
        .i_full  (q_full),
        .i_kind  (i_kind),
        .i_value (i_value),
        .o_wr    (f_wr),
        .o_cmd   (f_cmd)
    );

    // Command queue between classifier and generator.
    pfmt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (f_wr),
        .i_cmd   (f_cmd),
        .i_rd    (q_rd),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_cmd   (q_cmd)
    );

    // Character generation.
    pfmt_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_empty    (q_empty),
        .i_cmd        (q_cmd),
        .o_q_rd       (q_rd),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_character  (o_character),
        .o_last       (o_last),
        .o_char_count (o_char_count)
    );

endmodule
